/* rtl/rrog_pkg.sv */
package rrog_pkg;

  // Default widths for the top-level parameters
  localparam int DEF_COORD_WIDTH    = 16;
  localparam int DEF_TRIG_FRAC_BITS = 14;

  // Fixed field widths and codes
  localparam int RATE_W      = 9;
  localparam int IDX_W       = 6;
  localparam int SEG_W       = 4;
  localparam int ARC_W       = 2;
  localparam int MASTER_BITS = 20;
  localparam int RADIUS_SHIFT = 9;

  localparam logic [RATE_W-1:0] RATE_ONE  = 9'd256;
  localparam logic [SEG_W-1:0]  SEG_BASE  = 4'd2;
  localparam logic [ARC_W-1:0]  ARC_LAST  = 2'd3;
  localparam logic [IDX_W-1:0]  CORNER_LAST = 6'd3;
  localparam logic [IDX_W-1:0]  IDX_MAX   = 6'd43;

  // Corner arcs in emission order
  localparam logic [ARC_W-1:0] ARC_BR = 2'd0;
  localparam logic [ARC_W-1:0] ARC_TR = 2'd1;
  localparam logic [ARC_W-1:0] ARC_TL = 2'd2;
  localparam logic [ARC_W-1:0] ARC_BL = 2'd3;

  // cos(k*pi/(2n)) in Q1.20, row n-2, column k
  localparam logic [MASTER_BITS:0] COS_Q20 [9][11] = '{
    '{21'd1048576, 21'd741455, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0,
      21'd0, 21'd0},
    '{21'd1048576, 21'd908093, 21'd524288, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0,
      21'd0, 21'd0, 21'd0},
    '{21'd1048576, 21'd968758, 21'd741455, 21'd401273, 21'd0, 21'd0, 21'd0,
      21'd0, 21'd0, 21'd0, 21'd0},
    '{21'd1048576, 21'd997255, 21'd848316, 21'd616338, 21'd324028, 21'd0, 21'd0,
      21'd0, 21'd0, 21'd0, 21'd0},
    '{21'd1048576, 21'd1012847, 21'd908093, 21'd741455, 21'd524288, 21'd271391,
      21'd0, 21'd0, 21'd0, 21'd0, 21'd0},
    '{21'd1048576, 21'd1022286, 21'd944734, 21'd819810, 21'd653776, 21'd454960,
      21'd233330, 21'd0, 21'd0, 21'd0, 21'd0},
    '{21'd1048576, 21'd1028428, 21'd968758, 21'd871859, 21'd741455, 21'd582558,
      21'd401273, 21'd204567, 21'd0, 21'd0, 21'd0},
    '{21'd1048576, 21'd1032646, 21'd985339, 21'd908093, 21'd803256, 21'd674012,
      21'd524288, 21'd358634, 21'd182083, 21'd0, 21'd0},
    '{21'd1048576, 21'd1035666, 21'd997255, 21'd934288, 21'd848316, 21'd741455,
      21'd616338, 21'd476044, 21'd324028, 21'd164033, 21'd0}
  };

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RAD,
    S_RADW,
    S_CORNER,
    S_MULC,
    S_MULS,
    S_VTX
  } state_t;

  // Vertex handoff from sequencer to output register
  typedef struct packed {
    logic             load;
    logic             last;
    logic [IDX_W-1:0] index;
  } vtx_ctl_t;

endpackage

/* rtl/rrog_mul.sv */
module rrog_mul #(
  parameter int A_W = rrog_pkg::DEF_COORD_WIDTH,
  parameter int B_W = rrog_pkg::DEF_TRIG_FRAC_BITS + 1
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] prod_r
);

  logic [A_W+B_W-1:0] prod_nxt;

  // Unsigned product, registered
  assign prod_nxt = {{B_W{1'b0}}, a} * {{A_W{1'b0}}, b};

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

/* rtl/rrog_trig.sv */
module rrog_trig #(
  parameter int TRIG_FRAC_BITS = rrog_pkg::DEF_TRIG_FRAC_BITS
) (
  input  logic [rrog_pkg::SEG_W-1:0] seg_n,
  input  logic [rrog_pkg::SEG_W-1:0] seg_k,
  output logic [TRIG_FRAC_BITS:0]    trig_val
);

  localparam int SH = rrog_pkg::MASTER_BITS - TRIG_FRAC_BITS;
  localparam int MW = rrog_pkg::MASTER_BITS + 2;

  logic [rrog_pkg::SEG_W-1:0]    row;
  logic [rrog_pkg::MASTER_BITS:0] master;
  logic [MW-1:0]                 dbl;
  logic [MW-1:0]                 rnd;

  // Table row for n segments, then round Q1.20 half up to Q1.TRIG_FRAC_BITS
  assign row      = seg_n - rrog_pkg::SEG_BASE;
  assign master   = rrog_pkg::COS_Q20[row][seg_k];
  assign dbl      = {master, 1'b0} >> SH;
  assign rnd      = dbl + MW'(1);
  assign trig_val = rnd[TRIG_FRAC_BITS+1:1];

endmodule

/* rtl/rrog_seq.sv */
module rrog_seq #(
  parameter int COORD_WIDTH    = rrog_pkg::DEF_COORD_WIDTH,
  parameter int TRIG_FRAC_BITS = rrog_pkg::DEF_TRIG_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]     x_min,
  input  logic signed [COORD_WIDTH-1:0]     x_max,
  input  logic signed [COORD_WIDTH-1:0]     y_min,
  input  logic signed [COORD_WIDTH-1:0]     y_max,
  input  logic [rrog_pkg::RATE_W-1:0]       round_rate,
  input  logic                              out_free,
  output rrog_pkg::vtx_ctl_t                vtx_ctl,
  output logic signed [COORD_WIDTH-1:0]     vtx_x,
  output logic signed [COORD_WIDTH-1:0]     vtx_y
);

  localparam int CW  = COORD_WIDTH;
  localparam int BW  = TRIG_FRAC_BITS + 1;
  localparam int PW  = CW + BW;
  localparam int RW  = CW - 1;
  localparam int EW  = CW + 2;
  localparam logic [PW:0]          HALF   = (PW+1)'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [EW-1:0] SAT_HI = {3'b000, {(CW-1){1'b1}}};
  localparam logic signed [EW-1:0] SAT_LO = {3'b111, {(CW-1){1'b0}}};

  rrog_pkg::state_t state_r, state_nxt;

  // Latched rectangle and derived values
  logic signed [CW-1:0] xa_r, xb_r, ya_r, yb_r;
  logic [rrog_pkg::RATE_W-1:0] q_r, q_nxt;
  logic [rrog_pkg::SEG_W-1:0]  n_r, n_nxt;
  logic [RW-1:0]               r_r, r_nxt;
  logic [RW-1:0]               cv_r, cv_nxt;

  // Loop counters
  logic [rrog_pkg::SEG_W-1:0] i_r, i_nxt;
  logic [rrog_pkg::ARC_W-1:0] arc_r, arc_nxt;
  logic [rrog_pkg::IDX_W-1:0] idx_r, idx_nxt;

  // Shared multiplier and trig lookup
  logic                       mul_en;
  logic [CW-1:0]              mul_a;
  logic [BW-1:0]              mul_b;
  logic [PW-1:0]              prod_r;
  logic [rrog_pkg::SEG_W-1:0] trig_k;
  logic [BW-1:0]              trig_val;

  logic signed [CW:0]   w, h, m;
  logic [CW-1:0]        m_pos;
  logic [PW:0]          rsum;
  logic [RW-1:0]        offs;
  logic signed [EW-1:0] r_e, cv_e, sv_e, bx, by, vx, vy;
  logic                 seg_end, arc_end;

  rrog_mul #(.A_W(CW), .B_W(BW)) u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  rrog_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig (
    .seg_n    (n_r),
    .seg_k    (trig_k),
    .trig_val (trig_val)
  );

  // Shortest side, clamped at zero
  assign w     = {xb_r[CW-1], xb_r} - {xa_r[CW-1], xa_r};
  assign h     = {yb_r[CW-1], yb_r} - {ya_r[CW-1], ya_r};
  assign m     = (h < w) ? h : w;
  assign m_pos = (m > 0) ? m[CW-1:0] : '0;

  // Rounded arc offset from the registered product
  assign rsum = {1'b0, prod_r} + HALF;
  assign offs = rsum[TRIG_FRAC_BITS +: RW];

  assign r_e  = EW'(signed'({1'b0, r_r}));
  assign cv_e = EW'(signed'({1'b0, cv_r}));
  assign sv_e = EW'(signed'({1'b0, offs}));

  // Arc center and vertex for the current arc
  always_comb begin
    bx = '0;
    by = '0;
    vx = '0;
    vy = '0;
    case (arc_r)
      rrog_pkg::ARC_BR: begin
        bx = EW'(xb_r) - r_e;
        by = EW'(ya_r) + r_e;
        vx = bx + sv_e;
        vy = by - cv_e;
      end
      rrog_pkg::ARC_TR: begin
        bx = EW'(xb_r) - r_e;
        by = EW'(yb_r) - r_e;
        vx = bx + cv_e;
        vy = by + sv_e;
      end
      rrog_pkg::ARC_TL: begin
        bx = EW'(xa_r) + r_e;
        by = EW'(yb_r) - r_e;
        vx = bx - sv_e;
        vy = by + cv_e;
      end
      default: begin
        bx = EW'(xa_r) + r_e;
        by = EW'(ya_r) + r_e;
        vx = bx - cv_e;
        vy = by - sv_e;
      end
    endcase
  end

  assign seg_end = (i_r == n_r);
  assign arc_end = (arc_r == rrog_pkg::ARC_LAST);
  assign trig_k  = (state_r == rrog_pkg::S_MULC) ? i_r : (n_r - i_r);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrog_pkg::S_IDLE;
      i_r     <= '0;
      arc_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      arc_r   <= arc_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Item payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      xa_r <= x_min;
      xb_r <= x_max;
      ya_r <= y_min;
      yb_r <= y_max;
    end
    q_r  <= q_nxt;
    n_r  <= n_nxt;
    r_r  <= r_nxt;
    cv_r <= cv_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    arc_nxt   = arc_r;
    idx_nxt   = idx_r;
    q_nxt     = q_r;
    n_nxt     = n_r;
    r_nxt     = r_r;
    cv_nxt    = cv_r;
    in_ready  = 1'b0;
    mul_en    = 1'b0;
    mul_a     = {1'b0, r_r};
    mul_b     = trig_val;
    vtx_ctl   = '{load: 1'b0, last: 1'b0, index: idx_r};
    vtx_x     = '0;
    vtx_y     = '0;

    unique case (state_r)
      rrog_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          q_nxt     = (round_rate > rrog_pkg::RATE_ONE) ? rrog_pkg::RATE_ONE : round_rate;
          n_nxt     = q_nxt[8:5] + rrog_pkg::SEG_BASE;
          i_nxt     = '0;
          arc_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = rrog_pkg::S_RAD;
        end
      end
      rrog_pkg::S_RAD: begin
        mul_en    = 1'b1;
        mul_a     = m_pos;
        mul_b     = BW'(q_r);
        state_nxt = rrog_pkg::S_RADW;
      end
      rrog_pkg::S_RADW: begin
        r_nxt     = prod_r[rrog_pkg::RADIUS_SHIFT +: RW];
        state_nxt = (r_nxt == '0) ? rrog_pkg::S_CORNER : rrog_pkg::S_MULC;
      end
      rrog_pkg::S_CORNER: begin
        // Plain corners: TL, TR, BR, BL
        vtx_x = (idx_r[0] ^ idx_r[1]) ? xb_r : xa_r;
        vtx_y = idx_r[1] ? ya_r : yb_r;
        vtx_ctl.last = (idx_r == rrog_pkg::CORNER_LAST);
        if (out_free) begin
          vtx_ctl.load = 1'b1;
          idx_nxt      = idx_r + 1'b1;
          if (vtx_ctl.last) begin
            state_nxt = rrog_pkg::S_IDLE;
          end
        end
      end
      rrog_pkg::S_MULC: begin
        mul_en    = 1'b1;
        state_nxt = rrog_pkg::S_MULS;
      end
      rrog_pkg::S_MULS: begin
        mul_en    = 1'b1;
        cv_nxt    = offs;
        state_nxt = rrog_pkg::S_VTX;
      end
      rrog_pkg::S_VTX: begin
        vtx_x = (vx > SAT_HI) ? SAT_HI[CW-1:0] :
                (vx < SAT_LO) ? SAT_LO[CW-1:0] : vx[CW-1:0];
        vtx_y = (vy > SAT_HI) ? SAT_HI[CW-1:0] :
                (vy < SAT_LO) ? SAT_LO[CW-1:0] : vy[CW-1:0];
        vtx_ctl.last = seg_end && arc_end;
        if (out_free) begin
          vtx_ctl.load = 1'b1;
          idx_nxt      = idx_r + 1'b1;
          if (vtx_ctl.last) begin
            state_nxt = rrog_pkg::S_IDLE;
          end else begin
            state_nxt = rrog_pkg::S_MULC;
            if (seg_end) begin
              i_nxt   = '0;
              arc_nxt = arc_r + 1'b1;
            end else begin
              i_nxt = i_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = rrog_pkg::S_IDLE;
      end
    endcase
  end

  // A final vertex always hands control back to the input side
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    vtx_ctl.load && vtx_ctl.last |=> in_ready)
    else $error("no return to idle after final vertex");

  // Outline never exceeds 44 vertices
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    vtx_ctl.load |-> vtx_ctl.index <= rrog_pkg::IDX_MAX)
    else $error("vertex index out of range");

  // Plain-corner outline ends on its fourth vertex
  a_corner_last: assert property (@(posedge clk) disable iff (!rst_n)
    vtx_ctl.load && state_r == rrog_pkg::S_CORNER |->
      vtx_ctl.last == (vtx_ctl.index == rrog_pkg::CORNER_LAST))
    else $error("corner outline last flag wrong");

  // Rounded outline ends after four arcs of n+1 points
  a_arc_last: assert property (@(posedge clk) disable iff (!rst_n)
    vtx_ctl.load && vtx_ctl.last && state_r == rrog_pkg::S_VTX |->
      vtx_ctl.index == ({n_r, 2'b00} + rrog_pkg::CORNER_LAST))
    else $error("arc outline vertex count wrong");

endmodule

/* rtl/round_rectangle_outline_generator.sv */
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_tvalid/tready   | in_tdata: x_min, x_max, y_min, y_max, round_rate
// out_    | out | out_tvalid/tready  | out_tdata: vertex_x, vertex_y, vertex_index;
//         |     |                    | out_tlast: last_vertex
//
// Each vertex passes through the shared multiplier in S_MULC (cosine product),
// S_MULS (sine product) and S_VTX (combine); setup runs through S_RAD and
// S_RADW. A rounded outline has n+1 points per corner, n = 10 at the full rate of 1.0.
// A zero radius gives four plain corners.
// rst_n is synchronous, active low; it clears the sequencer and output valid.
// Output stalls hold the sequencer on the pending vertex; in_tready is high
// only while no rectangle is in progress.
module round_rectangle_outline_generator #(
  parameter int COORD_WIDTH    = rrog_pkg::DEF_COORD_WIDTH,
  parameter int TRIG_FRAC_BITS = rrog_pkg::DEF_TRIG_FRAC_BITS,
  localparam int IN_W  = ((4 * COORD_WIDTH + rrog_pkg::RATE_W + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_WIDTH + rrog_pkg::IDX_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // x_min, x_max, y_min, y_max, round_rate, zero pad
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // vertex_x, vertex_y, vertex_index, zero pad
  output logic             out_tlast
);

  localparam int CW = COORD_WIDTH;
  localparam int PAD_W = OUT_W - (2 * CW + rrog_pkg::IDX_W);

  logic signed [CW-1:0]        x_min, x_max, y_min, y_max;
  logic [rrog_pkg::RATE_W-1:0] round_rate;
  rrog_pkg::vtx_ctl_t          vtx_ctl;
  logic signed [CW-1:0]        vtx_x, vtx_y;
  logic                        out_free;

  logic                        out_valid_r;
  logic [CW-1:0]               out_x_r, out_y_r;
  logic [rrog_pkg::IDX_W-1:0]  out_idx_r;
  logic                        out_last_r;

  // Unpack the input transaction
  assign x_min      = signed'(in_tdata[0*CW +: CW]);
  assign x_max      = signed'(in_tdata[1*CW +: CW]);
  assign y_min      = signed'(in_tdata[2*CW +: CW]);
  assign y_max      = signed'(in_tdata[3*CW +: CW]);
  assign round_rate = in_tdata[4*CW +: rrog_pkg::RATE_W];

  assign out_free = !out_valid_r || out_tready;

  rrog_seq #(
    .COORD_WIDTH    (COORD_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .x_min      (x_min),
    .x_max      (x_max),
    .y_min      (y_min),
    .y_max      (y_max),
    .round_rate (round_rate),
    .out_free   (out_free),
    .vtx_ctl    (vtx_ctl),
    .vtx_x      (vtx_x),
    .vtx_y      (vtx_y)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= vtx_ctl.load;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (vtx_ctl.load) begin
      out_x_r    <= vtx_x;
      out_y_r    <= vtx_y;
      out_idx_r  <= vtx_ctl.index;
      out_last_r <= vtx_ctl.last;
    end
  end

  // Pack the output transaction
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_idx_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

endmodule

/* bench/rrog_outline_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the outline generator. For every accepted
// rectangle it traces the expected outline; every vertex transaction is
// compared with the oldest traced vertex.
module rrog_outline_checker #(
  parameter int CW    = rrog_pkg::DEF_COORD_WIDTH,
  parameter int TF    = rrog_pkg::DEF_TRIG_FRAC_BITS,
  parameter int IN_W  = ((4 * CW + rrog_pkg::RATE_W + 7) / 8) * 8,
  parameter int OUT_W = ((2 * CW + rrog_pkg::IDX_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // x_min, x_max, y_min, y_max, round_rate, zero pad
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,  // vertex_x, vertex_y, vertex_index, zero pad
  input  logic             out_tlast,
  output int               fail_count,
  output int               pending
);

  // cos(k*pi/(2n)) in Q1.20, row n-2, column k
  localparam int unsigned COS_TAB [9][11] = '{
    '{1048576, 741455, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1048576, 908093, 524288, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1048576, 968758, 741455, 401273, 0, 0, 0, 0, 0, 0, 0},
    '{1048576, 997255, 848316, 616338, 324028, 0, 0, 0, 0, 0, 0},
    '{1048576, 1012847, 908093, 741455, 524288, 271391, 0, 0, 0, 0, 0},
    '{1048576, 1022286, 944734, 819810, 653776, 454960, 233330, 0, 0, 0, 0},
    '{1048576, 1028428, 968758, 871859, 741455, 582558, 401273, 204567, 0, 0, 0},
    '{1048576, 1032646, 985339, 908093, 803256, 674012, 524288, 358634, 182083,
      0, 0},
    '{1048576, 1035666, 997255, 934288, 848316, 741455, 616338, 476044, 324028,
      164033, 0}
  };

  typedef struct packed {
    logic [CW-1:0]              x;
    logic [CW-1:0]              y;
    logic [rrog_pkg::IDX_W-1:0] idx;
    logic                       last;
  } vertex_t;

  vertex_t pending_vertices[$];
  int      errs = 0;
  int      queued = 0;

  assign fail_count = errs;
  assign pending    = queued;

  // Q1.20 table entry rounded half up to Q1.TF
  function automatic longint trig_value(int n, int k);
    longint v;
    v = longint'(COS_TAB[n - 2][k]);
    return (((v <<< 1) >>> (rrog_pkg::MASTER_BITS - TF)) + 1) >>> 1;
  endfunction

  // radius times trig, rounded half up
  function automatic longint arc_offset(longint r, longint c);
    return (r * c + (longint'(1) <<< (TF - 1))) >>> TF;
  endfunction

  function automatic logic [CW-1:0] clamp_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  function automatic void add_vertex(longint x, longint y, int k, bit last);
    vertex_t v;
    v.x    = clamp_coord(x);
    v.y    = clamp_coord(y);
    v.idx  = k[rrog_pkg::IDX_W-1:0];
    v.last = last;
    pending_vertices.insert(pending_vertices.size(), v);
  endfunction

  // Expected outline of one rectangle
  function automatic void trace_outline(logic [IN_W-1:0] d);
    longint xa, xb, ya, yb, w, h, m, r, cv, sv, vx, vy;
    int     q, n, k, total;
    xa = longint'($signed(d[0 +: CW]));
    xb = longint'($signed(d[CW +: CW]));
    ya = longint'($signed(d[2 * CW +: CW]));
    yb = longint'($signed(d[3 * CW +: CW]));
    q  = int'(d[4 * CW +: rrog_pkg::RATE_W]);
    if (q > int'(rrog_pkg::RATE_ONE)) q = int'(rrog_pkg::RATE_ONE);
    n = (q >> 5) + int'(rrog_pkg::SEG_BASE);
    w = xb - xa;
    h = yb - ya;
    m = (h < w) ? h : w;
    r = 0;
    if (m > 0) r = (m * q) >>> rrog_pkg::RADIUS_SHIFT;

    // no usable radius: the four plain corners
    if (r <= 0) begin
      add_vertex(xa, yb, 0, 1'b0);
      add_vertex(xb, yb, 1, 1'b0);
      add_vertex(xb, ya, 2, 1'b0);
      add_vertex(xa, ya, int'(rrog_pkg::CORNER_LAST), 1'b1);
      return;
    end

    total = 4 * (n + 1);
    k = 0;
    for (int arc = 0; arc < 4; arc++) begin
      for (int i = 0; i <= n; i++) begin
        cv = arc_offset(r, trig_value(n, i));
        sv = arc_offset(r, trig_value(n, n - i));
        case (arc[rrog_pkg::ARC_W-1:0])
          rrog_pkg::ARC_BR: begin
            vx = xb - r + sv;
            vy = ya + r - cv;
          end
          rrog_pkg::ARC_TR: begin
            vx = xb - r + cv;
            vy = yb - r + sv;
          end
          rrog_pkg::ARC_TL: begin
            vx = xa + r - sv;
            vy = yb - r + cv;
          end
          default: begin
            vx = xa + r - cv;
            vy = ya + r - sv;
          end
        endcase
        add_vertex(vx, vy, k, k == total - 1);
        k++;
      end
    end
  endfunction

  function automatic void note_failure(string what, vertex_t want, vertex_t got);
    string exp_s, got_s;
    errs++;
    if (errs <= 10) begin
      exp_s = $sformatf("x=%0d y=%0d idx=%0d last=%0b",
                        $signed(want.x), $signed(want.y), want.idx, want.last);
      got_s = $sformatf("x=%0d y=%0d idx=%0d last=%0b",
                        $signed(got.x), $signed(got.y), got.idx, got.last);
      $display("%0t ERROR %s: expected %s, got %s", $realtime, what, exp_s, got_s);
    end
  endfunction

  // Trace on input transactions, compare on output transactions
  always @(posedge clk) begin
    vertex_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) trace_outline(in_tdata);
      if (out_tvalid && out_tready) begin
        got.x    = out_tdata[0 +: CW];
        got.y    = out_tdata[CW +: CW];
        got.idx  = out_tdata[2 * CW +: rrog_pkg::IDX_W];
        got.last = out_tlast;
        if (pending_vertices.size() == 0) begin
          note_failure("unexpected vertex", '0, got);
        end else begin
          want = pending_vertices.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.idx !== want.idx ||
              got.last !== want.last)
            note_failure("vertex mismatch", want, got);
        end
      end
    end
    queued <= pending_vertices.size();
  end

endmodule

/* bench/tb_round_rectangle_outline_generator.sv */
`timescale 1ns / 100ps

module tb_round_rectangle_outline_generator;

  localparam int CW    = rrog_pkg::DEF_COORD_WIDTH;
  localparam int IN_W  = ((4 * CW + rrog_pkg::RATE_W + 7) / 8) * 8;
  localparam int OUT_W = ((2 * CW + rrog_pkg::IDX_W + 7) / 8) * 8;
  localparam int NUM_RANDOM = 500;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;   // x_min, x_max, y_min, y_max, round_rate, zero pad
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;       // vertex_x, vertex_y, vertex_index, zero pad
  logic             out_tlast;
  int               fail_count;
  int               pending;

  int burst_left = 0;
  int rx_mode = 0;
  int rx_left = 0;

  round_rectangle_outline_generator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  rrog_outline_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: phases of full speed, random stalls and mostly stalled
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(4, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [IN_W-1:0] pack_rect(int xa, int xb, int ya, int yb, int rate);
    logic [IN_W-1:0] d;
    d = '0;
    d[0 +: CW]                    = xa[CW-1:0];
    d[CW +: CW]                   = xb[CW-1:0];
    d[2 * CW +: CW]               = ya[CW-1:0];
    d[3 * CW +: CW]               = yb[CW-1:0];
    d[4 * CW +: rrog_pkg::RATE_W] = rate[rrog_pkg::RATE_W-1:0];
    return d;
  endfunction

  // Mostly well-formed rectangles, some noise and degenerate shapes
  function automatic logic [IN_W-1:0] random_rect();
    int sel, xa, xb, ya, yb, rate;
    sel = $urandom_range(0, 99);
    if (sel < 12)
      return pack_rect($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 511));
    xa = int'($urandom_range(0, 65535)) - 32768;
    ya = int'($urandom_range(0, 65535)) - 32768;
    if (sel < 20) begin
      // thin, empty or inverted
      xb = xa + int'($urandom_range(0, 6)) - 3;
      yb = ya + int'($urandom_range(0, 1024)) - 512;
    end else begin
      xb = xa + int'($urandom_range(0, 1) ? $urandom_range(1, 1024) : $urandom_range(1, 65535));
      yb = ya + int'($urandom_range(0, 1) ? $urandom_range(1, 1024) : $urandom_range(1, 65535));
    end
    if (xb > 32767) xb = 32767;
    if (yb > 32767) yb = 32767;
    if (xb < -32768) xb = -32768;
    if (yb < -32768) yb = -32768;
    sel = $urandom_range(0, 9);
    if (sel == 0) rate = 0;
    else if (sel == 1) rate = $urandom_range(257, 511);
    else rate = $urandom_range(1, 256);
    if ($urandom_range(0, 1)) return pack_rect(xa, xb, ya, yb, rate);
    return pack_rect(xa, xb, yb, ya, rate) ^ ({IN_W{1'b0}});
  endfunction

  // One input transaction, with random gaps between bursts
  task automatic send_rect(logic [IN_W-1:0] d);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 160) : $urandom_range(1, 8))
        @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: rate extremes, most arc counts, degenerate shapes, range ends
    send_rect(pack_rect(-1024, 1024, -512, 512, 0));
    send_rect(pack_rect(-1024, 1024, -512, 512, 256));
    send_rect(pack_rect(-1024, 1024, -512, 512, 511));
    send_rect(pack_rect(-1024, 1024, -512, 512, 257));
    send_rect(pack_rect(-1024, 1024, -512, 512, 1));
    send_rect(pack_rect(0, 3000, 0, 2000, 32));
    send_rect(pack_rect(0, 3000, 0, 2000, 96));
    send_rect(pack_rect(0, 3000, 0, 2000, 160));
    send_rect(pack_rect(0, 3000, 0, 2000, 224));
    send_rect(pack_rect(100, 400, -9000, 9000, 255));
    send_rect(pack_rect(1024, -1024, -512, 512, 256));
    send_rect(pack_rect(-1024, 1024, 512, -512, 256));
    send_rect(pack_rect(500, 500, 0, 800, 256));
    send_rect(pack_rect(0, 1, 0, 800, 256));
    send_rect(pack_rect(0, 2, 0, 800, 256));
    send_rect(pack_rect(-32768, 32767, -32768, 32767, 256));
    send_rect(pack_rect(-32768, 32767, -32768, 32767, 128));
    send_rect(pack_rect(-32768, -32768, -32768, -32768, 256));
    send_rect(pack_rect(32767, -32768, 32767, -32768, 511));
    send_rect(pack_rect(-32768, 32767, 32000, 32767, 64));

    // Random rectangles, with one pause until the outlines are drained
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 2) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_rect(random_rect());
    end
    in_tvalid <= 1'b0;

    // Drain and settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
